>>> rtl/core/quat_scale_translate_to_matrix_top_defines.svh
// ----------------------------------------------------------------------------
// Quaternion transform expander: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUAT_SCALE_TRANSLATE_TO_MATRIX_TOP_DEFINES_SVH
`define QUAT_SCALE_TRANSLATE_TO_MATRIX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSTM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qstm check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define QSTM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qstm check failed in the next cycle");

`endif

>>> rtl/core/qstm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion transform expander: package
// Types and constants shared by the sequencer and lanes, and the operand selection.
// ----------------------------------------------------------------------------
package qstm_pkg;

  localparam int NUM_LANES  = 3;
  localparam int NUM_STAGES = 10;
  localparam int FRAC_BITS  = 16;

  localparam logic [1:0] ROW_0    = 2'd0;
  localparam logic [1:0] ROW_1    = 2'd1;
  localparam logic [1:0] ROW_2    = 2'd2;
  localparam logic [1:0] ROW_3    = 2'd3;
  localparam logic [1:0] ROW_LAST = ROW_3;

  localparam logic [1:0] COL_A = 2'd0;
  localparam logic [1:0] COL_B = 2'd1;
  localparam logic [1:0] COL_C = 2'd2;

  localparam logic signed [31:0] ELEM_ONE = 32'sd1 <<< FRAC_BITS;

  // The component unit is 1/32767; entries are scaled by its square.
  localparam logic signed [33:0] QUAT_D2 = 34'sd1073676289;
  localparam logic [63:0]        HALF_D2 = 64'd536838144;

  // Multiples of 32767 for the end correction of the digit-sum divider.
  localparam logic [17:0] DIV_X1 = 18'd32767;
  localparam logic [17:0] DIV_X2 = 18'd65534;
  localparam logic [17:0] DIV_X3 = 18'd98301;
  localparam logic [17:0] DIV_X4 = 18'd131068;
  localparam logic [16:0] DIV_Y1 = 17'd32767;
  localparam logic [16:0] DIV_Y2 = 17'd65534;
  localparam logic [16:0] DIV_Y3 = 17'd98301;

  typedef struct packed {
    logic signed [15:0] a1;
    logic signed [15:0] a2;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic               neg_a;
    logic               neg_b;
    logic               diag;
    logic signed [31:0] scale;
  } qstm_op_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] row;
  } qstm_issue_t;

  // Each element is K + 2*(+/-a1*a2 +/- b1*b2), K being the unit square on
  // the diagonal. The last row uses K alone so that the scale passes through.
  function automatic qstm_op_t op_select(input logic [1:0] row, input logic [1:0] col,
                                         input logic signed [15:0] qx,
                                         input logic signed [15:0] qy,
                                         input logic signed [15:0] qz,
                                         input logic signed [15:0] qw,
                                         input logic signed [31:0] scale);
    qstm_op_t op;
    op = '0;
    op.scale = scale;
    unique case ({row, col})
      {ROW_0, COL_A}: begin
        op.diag = 1'b1;
        op.a1 = qy; op.a2 = qy; op.neg_a = 1'b1;
        op.b1 = qz; op.b2 = qz; op.neg_b = 1'b1;
      end
      {ROW_0, COL_B}: begin
        op.a1 = qx; op.a2 = qy;
        op.b1 = qw; op.b2 = qz;
      end
      {ROW_0, COL_C}: begin
        op.a1 = qx; op.a2 = qz;
        op.b1 = qw; op.b2 = qy; op.neg_b = 1'b1;
      end
      {ROW_1, COL_A}: begin
        op.a1 = qx; op.a2 = qy;
        op.b1 = qw; op.b2 = qz; op.neg_b = 1'b1;
      end
      {ROW_1, COL_B}: begin
        op.diag = 1'b1;
        op.a1 = qx; op.a2 = qx; op.neg_a = 1'b1;
        op.b1 = qz; op.b2 = qz; op.neg_b = 1'b1;
      end
      {ROW_1, COL_C}: begin
        op.a1 = qy; op.a2 = qz;
        op.b1 = qw; op.b2 = qx;
      end
      {ROW_2, COL_A}: begin
        op.a1 = qx; op.a2 = qz;
        op.b1 = qw; op.b2 = qy;
      end
      {ROW_2, COL_B}: begin
        op.a1 = qy; op.a2 = qz;
        op.b1 = qw; op.b2 = qx; op.neg_b = 1'b1;
      end
      {ROW_2, COL_C}: begin
        op.diag = 1'b1;
        op.a1 = qx; op.a2 = qx; op.neg_a = 1'b1;
        op.b1 = qy; op.b2 = qy; op.neg_b = 1'b1;
      end
      {ROW_3, COL_A}, {ROW_3, COL_B}, {ROW_3, COL_C}: begin
        op.diag = 1'b1;
      end
      default: begin
        op.diag = 1'b0;
      end
    endcase
    return op;
  endfunction

endpackage

>>> rtl/core/qstm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion transform expander: row sequencer
// Holds one transform and issues its four rows, one per advancing cycle.
// ----------------------------------------------------------------------------
module qstm_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_quat_x,
  input  logic signed [15:0]       in_quat_y,
  input  logic signed [15:0]       in_quat_z,
  input  logic signed [15:0]       in_quat_w,
  input  logic signed [31:0]       in_scale_x,
  input  logic signed [31:0]       in_scale_y,
  input  logic signed [31:0]       in_scale_z,
  input  logic signed [31:0]       in_move_x,
  input  logic signed [31:0]       in_move_y,
  input  logic signed [31:0]       in_move_z,
  output qstm_pkg::qstm_issue_t    issue,
  output qstm_pkg::qstm_op_t       ops [qstm_pkg::NUM_LANES]
);
  import qstm_pkg::*;

  logic               hold_v_r, hold_v_nxt;
  logic [1:0]         row_r, row_nxt;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0] sc_r [NUM_LANES];
  logic signed [31:0] mv_r [NUM_LANES];
  logic signed [31:0] row_scale;
  logic               fire, done, accept;

  // No transfer is taken while reset is asserted.
  assign fire     = hold_v_r & adv;
  assign done     = fire & (row_r == ROW_LAST);
  assign in_ready = rst_n & (~hold_v_r | done);
  assign accept   = in_valid & in_ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    row_nxt    = row_r;
    if (accept) begin
      hold_v_nxt = 1'b1;
      row_nxt    = ROW_0;
    end else if (fire) begin
      hold_v_nxt = ~done;
      row_nxt    = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      row_r    <= ROW_0;
    end else begin
      hold_v_r <= hold_v_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r    <= in_quat_x;
      qy_r    <= in_quat_y;
      qz_r    <= in_quat_z;
      qw_r    <= in_quat_w;
      sc_r[0] <= in_scale_x;
      sc_r[1] <= in_scale_y;
      sc_r[2] <= in_scale_z;
      mv_r[0] <= in_move_x;
      mv_r[1] <= in_move_y;
      mv_r[2] <= in_move_z;
    end
  end

  always_comb begin
    unique case (row_r)
      ROW_0:   row_scale = sc_r[0];
      ROW_1:   row_scale = sc_r[1];
      ROW_2:   row_scale = sc_r[2];
      default: row_scale = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ops[i] = op_select(row_r, 2'(i), qx_r, qy_r, qz_r, qw_r,
                         (row_r == ROW_LAST) ? mv_r[i] : row_scale);
    end
  end

  assign issue.vld = hold_v_r;
  assign issue.row = row_r;

endmodule

>>> rtl/core/qstm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion transform expander: element lane
// Ten-stage datapath for one matrix element: products, numerator, scaling,
// division by 32767 squared in two digit-sum steps, rounding and saturation.
// ----------------------------------------------------------------------------
module qstm_lane (
  input  logic                clk,
  input  logic                adv,
  input  qstm_pkg::qstm_op_t  op,
  output logic signed [31:0]  res
);
  import qstm_pkg::*;

  logic signed [31:0] pa_r, pb_r, pa_nxt, pb_nxt, sc1_r;
  logic               neg_a_r, neg_b_r, diag_r;

  logic signed [33:0] pa_ext, pb_ext, ta, tb, sum2, r_nxt, r_r;
  logic signed [31:0] sc2_r;

  logic [33:0] r_neg;
  logic [31:0] sc_neg;
  logic [32:0] un_nxt, un_r;
  logic [31:0] us_nxt, us_r;
  logic        neg3_nxt, neg3_r;

  logic [48:0] plo_nxt, phi_nxt, plo_r, phi_r;
  logic        neg4_r;

  logic [63:0] p_nxt, p_r;
  logic        neg5_r;

  logic [3:0]  t4_nxt, t4_r;
  logic [15:0] t3_nxt, t3_r;
  logic [16:0] t2_nxt, t2_r, t1_nxt, t1_r;
  logic [17:0] s0_nxt, s0_r;
  logic        neg6_r;

  logic [2:0]  c0;
  logic [48:0] q1_nxt, q1_r;
  logic        neg7_r;

  logic [3:0]  u3_nxt, u3_r;
  logic [15:0] u2_nxt, u2_r;
  logic [16:0] u1_nxt, u1_r, s1_nxt, s1_r;
  logic        neg8_r;

  logic [1:0]  c1;
  logic [33:0] q_nxt, q_r;
  logic        neg9_r;

  logic signed [31:0] res_nxt, res_r;

  always_comb begin
    pa_nxt = op.a1 * op.a2;
    pb_nxt = op.b1 * op.b2;

    pa_ext = {{2{pa_r[31]}}, pa_r};
    pb_ext = {{2{pb_r[31]}}, pb_r};
    ta     = neg_a_r ? -pa_ext : pa_ext;
    tb     = neg_b_r ? -pb_ext : pb_ext;
    sum2   = ta + tb;
    r_nxt  = (diag_r ? QUAT_D2 : 34'sd0) + (sum2 <<< 1);

    r_neg    = -r_r;
    sc_neg   = -sc2_r;
    un_nxt   = r_r[33] ? r_neg[32:0] : r_r[32:0];
    us_nxt   = sc2_r[31] ? sc_neg : sc2_r;
    neg3_nxt = r_r[33] ^ sc2_r[31];

    plo_nxt = un_r * us_r[15:0];
    phi_nxt = un_r * us_r[31:16];

    p_nxt = 64'(plo_r) + (64'(phi_r) << 16) + HALF_D2;

    t4_nxt = p_r[63:60];
    t3_nxt = 16'(p_r[59:45]) + 16'(t4_nxt);
    t2_nxt = 17'(p_r[44:30]) + 17'(t3_nxt);
    t1_nxt = 17'(p_r[29:15]) + t2_nxt;
    s0_nxt = 18'(p_r[14:0]) + 18'(t1_nxt);

    c0 = 3'(s0_r >= DIV_X1) + 3'(s0_r >= DIV_X2) + 3'(s0_r >= DIV_X3)
       + 3'(s0_r >= DIV_X4);
    q1_nxt = 49'(t1_r) + (49'(t2_r) << 15) + (49'(t3_r) << 30) + (49'(t4_r) << 45)
           + 49'(c0);

    u3_nxt = q1_r[48:45];
    u2_nxt = 16'(q1_r[44:30]) + 16'(u3_nxt);
    u1_nxt = 17'(q1_r[29:15]) + 17'(u2_nxt);
    s1_nxt = 17'(q1_r[14:0]) + u1_nxt;

    c1    = 2'(s1_r >= DIV_Y1) + 2'(s1_r >= DIV_Y2) + 2'(s1_r >= DIV_Y3);
    q_nxt = 34'(u1_r) + (34'(u2_r) << 15) + (34'(u3_r) << 30) + 34'(c1);

    if (!neg9_r) begin
      res_nxt = (q_r > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
    end else begin
      res_nxt = (q_r > 34'h080000000) ? 32'sh80000000 : $signed(32'd0 - q_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      neg_a_r <= op.neg_a;
      neg_b_r <= op.neg_b;
      diag_r  <= op.diag;
      sc1_r   <= op.scale;
      r_r     <= r_nxt;
      sc2_r   <= sc1_r;
      un_r    <= un_nxt;
      us_r    <= us_nxt;
      neg3_r  <= neg3_nxt;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      neg4_r  <= neg3_r;
      p_r     <= p_nxt;
      neg5_r  <= neg4_r;
      t4_r    <= t4_nxt;
      t3_r    <= t3_nxt;
      t2_r    <= t2_nxt;
      t1_r    <= t1_nxt;
      s0_r    <= s0_nxt;
      neg6_r  <= neg5_r;
      q1_r    <= q1_nxt;
      neg7_r  <= neg6_r;
      u3_r    <= u3_nxt;
      u2_r    <= u2_nxt;
      u1_r    <= u1_nxt;
      s1_r    <= s1_nxt;
      neg8_r  <= neg7_r;
      q_r     <= q_nxt;
      neg9_r  <= neg8_r;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> rtl/core/quat_scale_translate_to_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion transform to 4x4 matrix expander
// Expands a quaternion, per-row scales and a translation into four matrix
// rows of signed Q16.16 elements, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// Each accepted transform yields four row transfers, rows 0 to 3 in order, and
// the block accepts the next transform only as the last row of the current one
// is issued. The row sequencer issues one row into the three element lanes in
// each cycle in which the pipeline advances. An accepted transform is held in
// the sequencer registers, and each row it issues then passes through the
// ten-stage lane pipeline to the output. A stall on the output holds the whole
// pipeline in place. The quaternion is used as given, without normalization,
// and the translation row is passed through exactly.
`include "quat_scale_translate_to_matrix_top_defines.svh"

module quat_scale_translate_to_matrix_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  input  logic signed [31:0] in_move_x,
  input  logic signed [31:0] in_move_y,
  input  logic signed [31:0] in_move_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_elem_a,
  output logic signed [31:0] out_elem_b,
  output logic signed [31:0] out_elem_c,
  output logic signed [31:0] out_elem_d,
  output logic               out_last_row
);
  import qstm_pkg::*;

  localparam int LAST_STG = NUM_STAGES - 1;

  qstm_issue_t              issue;
  qstm_op_t                 ops [NUM_LANES];
  logic signed [31:0]       res [NUM_LANES];
  logic [NUM_STAGES-1:0]    vld_r, vld_nxt;
  logic [1:0]               row_r [NUM_STAGES];
  logic                     adv;

  assign adv = ~vld_r[LAST_STG] | out_ready;

  qstm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_quat_w  (in_quat_w),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .in_move_x  (in_move_x),
    .in_move_y  (in_move_y),
    .in_move_z  (in_move_z),
    .issue      (issue),
    .ops        (ops)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    qstm_lane u_lane (
      .clk (clk),
      .adv (adv),
      .op  (ops[i]),
      .res (res[i])
    );
  end

  assign vld_nxt = {vld_r[NUM_STAGES-2:0], issue.vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r[0] <= issue.row;
      for (int k = 1; k < NUM_STAGES; k++) begin
        row_r[k] <= row_r[k-1];
      end
    end
  end

  assign out_valid     = vld_r[LAST_STG];
  assign out_row_index = row_r[LAST_STG];
  assign out_last_row  = (row_r[LAST_STG] == ROW_LAST);
  assign out_elem_a    = res[0];
  assign out_elem_b    = res[1];
  assign out_elem_c    = res[2];
  assign out_elem_d    = out_last_row ? ELEM_ONE : 32'sd0;

  `QSTM_ASSERT_NEXT(a_row_order, adv && vld_r[0] && (row_r[0] != ROW_LAST), vld_r[0] && (row_r[0] == 2'($past(row_r[0]) + 2'd1)))
  `QSTM_ASSERT_NOW(a_busy_issues, !in_ready, issue.vld)
  `QSTM_ASSERT_NEXT(a_stall_holds, vld_r[LAST_STG] && !out_ready, $stable(vld_r))
  `QSTM_ASSERT_NEXT(a_take_one, in_valid && in_ready, !in_ready)

endmodule
